@@ rtl/core/hcbp_pkg.sv @@
`timescale 1ns / 1ps
package hcbp_pkg;

  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int FILL_W  = 3;
  localparam int SYM_W   = 8;
  localparam int ACT_W   = 2;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ENCODE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH  = 2'd2;

  // one unit of work for the packer
  typedef struct packed {
    logic              is_flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } op_t;

endpackage

@@ rtl/core/hcbp_front.sv @@
`timescale 1ns / 1ps
module hcbp_front #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [hcbp_pkg::ACT_W-1:0]   action,
  input  logic [hcbp_pkg::SYM_W-1:0]   symbol,
  input  logic [hcbp_pkg::CODE_W-1:0]  code_bits,
  input  logic [hcbp_pkg::LEN_W-1:0]   code_length,
  output logic                         op_push,
  output hcbp_pkg::op_t                op,
  input  logic                         op_full
);
  import hcbp_pkg::*;

  localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
  localparam int EFF_MAX = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  logic [CODE_W-1:0]       code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]        len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld;

  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_len;
  logic              rd_vld;

  logic s1_valid;
  logic s1_flush;
  logic s1_hit;

  logic              accept;
  logic              in_table;
  logic [ADDR_W-1:0] addr;
  logic [LEN_W-1:0]  len_sat;
  logic              s1_keep;

  assign accept   = push && !full;
  assign in_table = {1'b0, symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
  assign addr     = symbol[ADDR_W-1:0];
  assign len_sat  = (code_length > LEN_W'(EFF_MAX)) ? LEN_W'(EFF_MAX) : code_length;
  assign full     = s1_valid && op_full;

  always_ff @(posedge clk) begin
    if (accept && action == ACT_LOAD && in_table) begin
      code_mem[addr] <= code_bits;
      len_mem[addr]  <= len_sat;
    end
    if (accept && action == ACT_ENCODE) begin
      rd_code <= code_mem[addr];
      rd_len  <= len_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_vld   <= 1'b0;
      s1_valid <= 1'b0;
      s1_flush <= 1'b0;
      s1_hit   <= 1'b0;
    end else begin
      if (accept && action == ACT_LOAD && in_table) begin
        vld[addr] <= 1'b1;
      end
      if (accept && action == ACT_ENCODE) begin
        rd_vld <= vld[addr];
      end
      if (accept) begin
        s1_valid <= (action == ACT_ENCODE) || (action == ACT_FLUSH);
        s1_flush <= (action == ACT_FLUSH);
        s1_hit   <= in_table;
      end else if (!op_full) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // zero-length, unloaded and out-of-table encodes are dropped here
  assign s1_keep = s1_flush || (s1_hit && rd_vld && rd_len != '0);
  assign op_push = s1_valid && !op_full && s1_keep;

  always_comb begin
    op.is_flush = s1_flush;
    op.code     = rd_code;
    op.len      = rd_len;
  end

  a_full_needs_s1: assert property (@(posedge clk) disable iff (rst)
    full |-> s1_valid) else $error("full raised with stage 1 empty");

  a_push_len: assert property (@(posedge clk) disable iff (rst)
    (op_push && !op.is_flush) |-> (op.len != '0 && op.len <= LEN_W'(EFF_MAX)))
    else $error("encode transaction with bad length");

endmodule

@@ rtl/core/hcbp_queue.sv @@
`timescale 1ns / 1ps
module hcbp_queue #(
  parameter int DEPTH = hcbp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  hcbp_pkg::op_t wr_data,
  output logic          full,
  input  logic          rd,
  output hcbp_pkg::op_t rd_data,
  output logic          empty
);
  import hcbp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_wr) - CNT_W'(do_rd);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count overflow");

endmodule

@@ rtl/core/hcbp_back.sv @@
`timescale 1ns / 1ps
module hcbp_back (
  input  logic                         clk,
  input  logic                         rst,
  input  hcbp_pkg::op_t                op,
  input  logic                         op_empty,
  output logic                         op_pop,
  output logic                         empty,
  input  logic                         pop,
  output logic [hcbp_pkg::BYTE_W-1:0]  packed_byte,
  output logic                         last_of_run
);
  import hcbp_pkg::*;

  logic              busy;
  logic [CODE_W-1:0] cur;
  logic [LEN_W-1:0]  n;
  logic [BYTE_W-1:0] acc;
  logic [FILL_W-1:0] fill;
  logic              out_valid;

  logic              busy_next;
  logic [CODE_W-1:0] cur_next;
  logic [LEN_W-1:0]  n_next;
  logic [BYTE_W-1:0] acc_next;
  logic [FILL_W-1:0] fill_next;

  logic                out_load;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_last;
  logic                space;
  logic [FILL_W:0]     room;
  logic [FILL_W:0]     take;
  logic [FILL_W:0]     fill_sum;
  logic [LEN_W-1:0]    n_rem;
  logic [2*BYTE_W-1:0] merged;
  logic [BYTE_W-1:0]   flush_byte;

  assign empty = !out_valid;
  assign space = !out_valid || pop;

  assign room       = (FILL_W + 1)'(BYTE_W) - {1'b0, fill};
  assign take       = (n < LEN_W'(room)) ? n[FILL_W:0] : room;
  assign fill_sum   = {1'b0, fill} + take;
  assign n_rem      = n - LEN_W'(take);
  assign merged     = {acc, cur[CODE_W-1 -: BYTE_W]} << take;
  assign flush_byte = acc << ((FILL_W + 1)'(BYTE_W) - {1'b0, fill});

  always_comb begin
    busy_next = busy;
    cur_next  = cur;
    n_next    = n;
    acc_next  = acc;
    fill_next = fill;
    op_pop    = 1'b0;
    out_load  = 1'b0;
    out_byte  = merged[2*BYTE_W-1 -: BYTE_W];
    out_last  = 1'b1;
    if (busy) begin
      if (fill_sum == (FILL_W + 1)'(BYTE_W)) begin
        if (space) begin
          out_load  = 1'b1;
          out_last  = n_rem < LEN_W'(BYTE_W);
          acc_next  = '0;
          fill_next = '0;
          cur_next  = cur << take;
          n_next    = n_rem;
          busy_next = n_rem != '0;
        end
      end else begin
        acc_next  = merged[2*BYTE_W-1 -: BYTE_W];
        fill_next = fill_sum[FILL_W-1:0];
        cur_next  = cur << take;
        n_next    = n_rem;
        busy_next = n_rem != '0;
      end
    end else if (!op_empty) begin
      if (op.is_flush) begin
        if (fill == '0) begin
          op_pop = 1'b1;
        end else if (space) begin
          op_pop    = 1'b1;
          out_load  = 1'b1;
          out_byte  = flush_byte;
          acc_next  = '0;
          fill_next = '0;
        end
      end else begin
        op_pop    = 1'b1;
        busy_next = 1'b1;
        cur_next  = op.code << (LEN_W'(CODE_W) - op.len);
        n_next    = op.len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      acc       <= '0;
      fill      <= '0;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      acc  <= acc_next;
      fill <= fill_next;
      n    <= n_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (out_load) begin
      packed_byte <= out_byte;
      last_of_run <= out_last;
    end
  end

  a_busy_len: assert property (@(posedge clk) disable iff (rst)
    busy |-> n != '0) else $error("busy with no bits left");

  a_load_space: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || pop)) else $error("result overwritten");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    op_pop |-> !busy) else $error("op taken while busy");

endmodule

@@ rtl/core/huffman_code_bit_packer.sv @@
`timescale 1ns / 1ps
// Variable-length code packer.
// Input channel (push/full): action, symbol, code_bits, code_length. A load
// writes one code table entry; an encode appends the stored code to the bit
// stream, first bit first; a flush pads any partial byte with zeros and sends it.
// Result channel (empty/pop): packed_byte with the earliest bit in bit 7, and
// last_of_run set on the final byte of the input transaction that caused it.
// Input rate: one transaction per cycle while full is low, into an op queue of
// QUEUE_DEPTH entries (4 by default).
// The back end picks up an op from the queue and then packs the code one
// byte-aligned chunk at a time; it takes no new op until the code is done, and
// a flush is handled as it is picked up.
// Reset clears the code table (per-entry valid bits), the bit accumulator, the
// op queue and the result register. When pop is held low the packer stalls
// at the next byte to send, the queue fills and full is raised.
module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF,
  parameter int QUEUE_DEPTH  = hcbp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [hcbp_pkg::ACT_W-1:0]   action,
  input  logic [hcbp_pkg::SYM_W-1:0]   symbol,
  input  logic [hcbp_pkg::CODE_W-1:0]  code_bits,
  input  logic [hcbp_pkg::LEN_W-1:0]   code_length,
  output logic                         empty,
  input  logic                         pop,
  output logic [hcbp_pkg::BYTE_W-1:0]  packed_byte,
  output logic                         last_of_run
);
  import hcbp_pkg::*;

  op_t  f_op;
  logic f_push;
  logic q_full;
  op_t  q_op;
  logic q_empty;
  logic q_pop;

  hcbp_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .action(action),
    .symbol(symbol),
    .code_bits(code_bits),
    .code_length(code_length),
    .op_push(f_push),
    .op(f_op),
    .op_full(q_full)
  );

  hcbp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .wr(f_push),
    .wr_data(f_op),
    .full(q_full),
    .rd(q_pop),
    .rd_data(q_op),
    .empty(q_empty)
  );

  hcbp_back u_back (
    .clk(clk),
    .rst(rst),
    .op(q_op),
    .op_empty(q_empty),
    .op_pop(q_pop),
    .empty(empty),
    .pop(pop),
    .packed_byte(packed_byte),
    .last_of_run(last_of_run)
  );

endmodule

@@ verif/tb_huffman_code_bit_packer.sv @@
`timescale 1ns / 1ps
module tb_huffman_code_bit_packer;
  import hcbp_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 16;

  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    bit                drain_first;
  } code_req_t;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_byte_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              push = 1'b0;
  logic              full;
  logic [ACT_W-1:0]  action = '0;
  logic [SYM_W-1:0]  symbol = '0;
  logic [CODE_W-1:0] code_bits = '0;
  logic [LEN_W-1:0]  code_length = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [BYTE_W-1:0] packed_byte;
  logic              last_of_run;

  code_req_t code_reqs[$];
  out_byte_t pending_bytes[$];

  // predictor state
  bit [CODE_W-1:0] tbl_code [SYMBOL_COUNT_DEF];
  bit [LEN_W-1:0]  tbl_len [SYMBOL_COUNT_DEF];
  bit [BYTE_W-1:0] acc = '0;
  int              fill = 0;

  int n_err = 0;
  int n_in = 0;
  int n_out = 0;
  int n_act [4] = '{0, 0, 0, 0};
  int send_gap = 0;
  int recv_stall = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;
  code_req_t cur;

  huffman_code_bit_packer i_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .action      (action),
    .symbol      (symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .empty       (empty),
    .pop         (pop),
    .packed_byte (packed_byte),
    .last_of_run (last_of_run)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int gap_len(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_req(input logic [ACT_W-1:0] act, input int sym,
                         input logic [CODE_W-1:0] bits, input int len,
                         input bit drain_first = 1'b0);
    code_req_t r;
    r.act = act;
    r.sym = sym[SYM_W-1:0];
    r.bits = bits;
    r.len = len[LEN_W-1:0];
    r.drain_first = drain_first;
    code_reqs.push_back(r);
  endtask

  // expected bytes of one accepted transaction
  task automatic pack_bits(input code_req_t r);
    int n;
    int first;
    bit [CODE_W-1:0] c;
    first = pending_bytes.size();
    case (r.act)
      ACT_LOAD: begin
        n = r.len;
        if (n > MAX_CODE_LEN_DEF) n = MAX_CODE_LEN_DEF;
        if (n > CODE_W) n = CODE_W;
        c = r.bits;
        if (n < CODE_W) c = c & ((32'd1 << n) - 32'd1);
        tbl_code[r.sym] = c;
        tbl_len[r.sym] = n[LEN_W-1:0];
      end
      ACT_ENCODE: begin
        n = tbl_len[r.sym];
        c = tbl_code[r.sym];
        while (n > 0) begin
          n--;
          acc = {acc[BYTE_W-2:0], c[n]};
          fill++;
          if (fill == BYTE_W) begin
            pending_bytes.push_back('{acc, 1'b0});
            acc = '0;
            fill = 0;
          end
        end
      end
      ACT_FLUSH: begin
        if (fill > 0) begin
          acc = acc << (BYTE_W - fill);
          pending_bytes.push_back('{acc, 1'b0});
          acc = '0;
          fill = 0;
        end
      end
      default: ;
    endcase
    if (pending_bytes.size() > first) pending_bytes[pending_bytes.size() - 1].last = 1'b1;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        pack_bits(cur);
        n_act[cur.act]++;
        n_in++;
        send_gap = gap_len(((n_in / 40) % 3) == 1);
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (code_reqs.size() != 0 &&
                   !(code_reqs[0].drain_first && pending_bytes.size() != 0)) begin
        cur = code_reqs.pop_front();
        action <= cur.act;
        symbol <= cur.sym;
        code_bits <= cur.bits;
        code_length <= cur.len;
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    out_byte_t e;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_out++;
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected byte: expected none, got %02h last %0b",
                   $time, packed_byte, last_of_run);
          n_err++;
        end else begin
          e = pending_bytes.pop_front();
          if (packed_byte !== e.data) begin
            $display("%0t: packed_byte mismatch: expected %02h, got %02h",
                     $time, e.data, packed_byte);
            n_err++;
          end
          if (last_of_run !== e.last) begin
            $display("%0t: last_of_run mismatch: expected %0b, got %0b",
                     $time, e.last, last_of_run);
            n_err++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        pop <= 1'b0;
      end else if (!hold_done && n_out >= 60) begin
        // long back-pressure so the op queue fills and full rises
        hold_done = 1'b1;
        hold_cnt = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        recv_stall = gap_len(((n_out / 50) % 3) == 2);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d bytes still expected", $time, pending_bytes.size());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int live[$];
    int r;
    int s;
    int len;
    // directed
    add_req(ACT_ENCODE, 0, 32'h0, 0);
    add_req(ACT_FLUSH, 0, 32'h0, 0);
    add_req(ACT_UNUSED, 255, 32'hFFFF_FFFF, 63);
    add_req(ACT_LOAD, 0, 32'hA5C3_F00F, 32);
    add_req(ACT_LOAD, 255, 32'hFFFF_FFFF, 63);
    add_req(ACT_LOAD, 1, 32'hFFFF_FFFF, 1);
    add_req(ACT_LOAD, 2, 32'h0000_FFFF, 0);
    add_req(ACT_LOAD, 3, 32'h0000_0055, 7);
    add_req(ACT_LOAD, 4, 32'h8000_0000, 33);
    add_req(ACT_ENCODE, 0, 32'h0, 0);
    add_req(ACT_ENCODE, 255, 32'h0, 0);
    add_req(ACT_ENCODE, 1, 32'hFFFF_FFFF, 63);
    add_req(ACT_ENCODE, 2, 32'h0, 0);
    add_req(ACT_FLUSH, 0, 32'h0, 0);
    add_req(ACT_ENCODE, 1, 32'h0, 0);
    add_req(ACT_ENCODE, 3, 32'h0, 0);
    add_req(ACT_ENCODE, 3, 32'h0, 0);
    add_req(ACT_ENCODE, 0, 32'h0, 0);
    add_req(ACT_ENCODE, 4, 32'h0, 0);
    add_req(ACT_FLUSH, 255, 32'hFFFF_FFFF, 63);
    add_req(ACT_FLUSH, 0, 32'h0, 0);
    add_req(ACT_UNUSED, 0, 32'h0, 0);
    live = '{0, 1, 3, 4, 255};

    // random: mostly encodes of loaded symbols, with loads, flushes and some noise
    for (int k = 0; k < 360; k++) begin
      r = $urandom_range(0, 99);
      if (r < 20 || live.size() < 3) begin
        s = $urandom_range(0, 255);
        r = $urandom_range(0, 99);
        if (r < 60) len = $urandom_range(1, 12);
        else if (r < 85) len = $urandom_range(13, 32);
        else if (r < 95) len = $urandom_range(33, 63);
        else len = 0;
        if (len != 0) live.push_back(s);
        add_req(ACT_LOAD, s, $urandom, len, k == 0 || k == 200);
      end else if (r < 83) begin
        if ($urandom_range(0, 9) < 8) s = live[$urandom_range(0, live.size() - 1)];
        else s = $urandom_range(0, 255);
        add_req(ACT_ENCODE, s, $urandom, $urandom_range(0, 63), k == 0 || k == 200);
      end else if (r < 95) begin
        add_req(ACT_FLUSH, $urandom_range(0, 255), $urandom, $urandom_range(0, 63),
                k == 0 || k == 200);
      end else begin
        add_req(ACT_UNUSED, $urandom_range(0, 255), $urandom, $urandom_range(0, 63),
                k == 0 || k == 200);
      end
    end
    add_req(ACT_FLUSH, 0, 32'h0, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (code_reqs.size() != 0 || push || pending_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d transactions: %0d loads, %0d encodes, %0d flushes, %0d unused",
             n_in, n_act[ACT_LOAD], n_act[ACT_ENCODE], n_act[ACT_FLUSH], n_act[ACT_UNUSED]);
    $display("Checked %0d output bytes, %0d mismatches", n_out, n_err);
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/hcbp_pkg.sv
rtl/core/hcbp_front.sv
rtl/core/hcbp_queue.sv
rtl/core/hcbp_back.sv
rtl/core/huffman_code_bit_packer.sv
verif/tb_huffman_code_bit_packer.sv
